FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SITL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SITL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sitl_pkg.sv
// ----------------------------------------------------------------------------
// sitl_pkg
// request codes, status codes and fixed widths of the interval table lookup
// ----------------------------------------------------------------------------
package sitl_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LOC_W   = 16;
  localparam int unsigned ENTRY_W = ADDR_W + LOC_W;
  localparam int unsigned LCNT_W  = 17;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_ASCENDING = 3'd1;
  localparam logic [2:0] ST_BAD_LOCATION  = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd4;

  localparam logic [LCNT_W-1:0] LOC_COUNT_RESET = 17'h10000;
  localparam logic [ADDR_W-1:0] ADDR_MAX        = 32'hffff_ffff;

endpackage

FILE: src/sitl_ram.sv
// ----------------------------------------------------------------------------
// sitl_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module sitl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sorted_interval_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// sorted_interval_table_lookup_unit
// Keeps a table of strictly ascending 32-bit interval start addresses, each
// with a 16-bit location id, in one ram of TABLE_DEPTH entries. An append
// transaction adds an entry at the end after checking for a full table, a
// non-ascending start and an out-of-range location id (in that order). A
// lookup transaction binary-searches the table for the interval holding the
// address and returns its index, location id and bounds; the last interval
// ends at 0xffffffff, and an empty table or an address below the first start
// gives not found. A clear transaction empties the table. The block works on
// one transaction at a time: an append, clear or unused code is accepted,
// then its result waits in the done state until the output register is
// free and is loaded there. A lookup is accepted, compares the first entry,
// read from the ram while idle, then makes one halving step per cycle through
// the single registered ram read port and the one shared compare, and then
// loads the result register; a lookup on an empty table skips the search.
// The result sits in an output register, so a waiting result does not hold
// back the next transaction until its own result is ready. No clearing pass
// is done after reset: only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module sorted_interval_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] address,
  input  logic [15:0] location_id,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [15:0] entry_index,
  output logic [15:0] found_location,
  output logic [31:0] lower_bound,
  output logic [31:0] upper_bound,
  // configuration write channel (location count)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  // ram index width and fill count width (the count may reach the depth)
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,  // waiting for a request
    S_FIRST = 4'b0010,  // first entry on the read port
    S_PROBE = 4'b0100,  // one halving step per cycle
    S_DONE  = 4'b1000   // result waits for the output register
  } state_t;

  state_t state;

  // table bookkeeping
  logic [CW-1:0]                    entry_count;
  logic [sitl_pkg::ADDR_W-1:0]      last_start;
  logic [sitl_pkg::LCNT_W-1:0]      location_count;

  // search registers
  logic [sitl_pkg::ADDR_W-1:0]      addr_q;
  logic [CW-1:0]                    lo;
  logic [CW-1:0]                    hi;
  logic [CW-1:0]                    mid;
  logic [sitl_pkg::ENTRY_W-1:0]     lo_data;    // entry at lo
  logic [sitl_pkg::ADDR_W-1:0]      hi_start;   // start address at hi
  logic [2:0]                       pend_status;
  logic                             lookup_hit;

  // ram port
  logic                             ram_we;
  logic [AW-1:0]                    ram_raddr;
  logic [sitl_pkg::ENTRY_W-1:0]     ram_rdata;

  // combinational search step
  logic                             accept;
  logic                             out_free;
  logic [sitl_pkg::ADDR_W-1:0]      rd_start;
  logic                             le;
  logic [CW-1:0]                    lo_next;
  logic [CW-1:0]                    hi_next;
  logic [CW:0]                      sum;
  logic [CW-1:0]                    mid_next;
  logic [CW-1:0]                    span;
  logic                             more;
  logic [2:0]                       app_status;
  logic [31:0]                      idx_wide;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // append checks, first failure wins
  always_comb begin
    if (entry_count == DEPTH_CNT) begin
      app_status = sitl_pkg::ST_FULL;
    end else if (entry_count != '0 && address <= last_start) begin
      app_status = sitl_pkg::ST_NOT_ASCENDING;
    end else if ({1'b0, location_id} >= location_count) begin
      app_status = sitl_pkg::ST_BAD_LOCATION;
    end else begin
      app_status = sitl_pkg::ST_OK;
    end
  end

  assign ram_we = accept && (req_type == sitl_pkg::REQ_APPEND) &&
                  (app_status == sitl_pkg::ST_OK);

  // shared compare: probed start address against the looked-up address
  assign rd_start = ram_rdata[sitl_pkg::ENTRY_W-1:sitl_pkg::LOC_W];
  assign le       = (rd_start <= addr_q);

  // window after this step; the first step opens it as [0, count)
  always_comb begin
    if (state == S_PROBE) begin
      lo_next = le ? mid : lo;
      hi_next = le ? hi : mid;
    end else begin
      lo_next = '0;
      hi_next = entry_count;
    end
  end

  assign sum      = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = sum[CW:1];
  assign span     = hi_next - lo_next;
  assign more     = (span > CW'(1));

  // entry 0 is read while idle so it is ready in the first search cycle
  assign ram_raddr = (state == S_IDLE) ? '0 : mid_next[AW-1:0];

  assign idx_wide = 32'(lo);

  sitl_ram #(
    .WIDTH (sitl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[AW-1:0]),
    .wdata ({address, location_id}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_count    <= '0;
      last_start     <= '0;
      location_count <= sitl_pkg::LOC_COUNT_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        location_count <= cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q      <= address;
            lo          <= '0;
            lookup_hit  <= 1'b0;
            pend_status <= sitl_pkg::ST_OK;
            state       <= S_DONE;
            case (req_type)
              sitl_pkg::REQ_APPEND: begin
                pend_status <= app_status;
                if (app_status == sitl_pkg::ST_OK) begin
                  lo          <= entry_count;
                  last_start  <= address;
                  entry_count <= entry_count + CW'(1);
                end
              end
              sitl_pkg::REQ_LOOKUP: begin
                if (entry_count == '0) begin
                  pend_status <= sitl_pkg::ST_NOT_FOUND;
                end else begin
                  state <= S_FIRST;
                end
              end
              sitl_pkg::REQ_CLEAR: begin
                entry_count <= '0;
                last_start  <= '0;
              end
              default: begin
                // unused code: plain ok answer, nothing changes
              end
            endcase
          end
        end

        S_FIRST: begin
          if (!le) begin
            // address below the first start
            pend_status <= sitl_pkg::ST_NOT_FOUND;
            state       <= S_DONE;
          end else begin
            lo         <= lo_next;
            hi         <= hi_next;
            mid        <= mid_next;
            lo_data    <= ram_rdata;
            lookup_hit <= 1'b1;
            state      <= more ? S_PROBE : S_DONE;
          end
        end

        S_PROBE: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (le) begin
            lo_data <= ram_rdata;
          end else begin
            hi_start <= rd_start;
          end
          if (!more) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            status      <= pend_status;
            entry_index <= idx_wide[15:0];
            if (lookup_hit) begin
              found_location <= lo_data[sitl_pkg::LOC_W-1:0];
              lower_bound    <= lo_data[sitl_pkg::ENTRY_W-1:sitl_pkg::LOC_W];
              // hi is lo + 1 here; the last entry runs to the top
              upper_bound    <= (hi < entry_count) ? (hi_start - 32'd1)
                                                   : sitl_pkg::ADDR_MAX;
            end else begin
              found_location <= '0;
              lower_bound    <= '0;
              upper_bound    <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/sitl_checker.sv
// ----------------------------------------------------------------------------
// sitl_checker
// port-level checks of the interval table lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitl_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [2:0]  status,
  input logic [15:0] entry_index,
  input logic [15:0] found_location,
  input logic [31:0] lower_bound,
  input logic [31:0] upper_bound
);

  // a stalled response holds
  `SITL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(entry_index) && $stable(lower_bound) && $stable(upper_bound), "stalled response changed")

  // one transaction at a time: busy right after an accept
  `SITL_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "request taken while busy")

  // any failure carries all-zero fields
  `SITL_ASSERT_SAME(a_fail_zero, clk, rst, rsp_valid && status != sitl_pkg::ST_OK, entry_index == 16'd0 && found_location == 16'd0 && lower_bound == 32'd0 && upper_bound == 32'd0, "failure with non-zero fields")

  // a found interval is never empty
  `SITL_ASSERT_SAME(a_bounds_order, clk, rst, rsp_valid && status == sitl_pkg::ST_OK, lower_bound <= upper_bound, "interval bounds out of order")

endmodule

bind sorted_interval_table_lookup_unit sitl_checker u_sitl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .entry_index    (entry_index),
  .found_location (found_location),
  .lower_bound    (lower_bound),
  .upper_bound    (upper_bound)
);
